[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, codes and the segment table shared by the display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int FRAME_LEN = 5;
  localparam int DP_POS    = 2;
  localparam logic [7:0] DP_CODE    = 8'h80;
  localparam logic [7:0] BLANK_CODE = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    CFG_FIRST_POSITION = 1'b0,
    CFG_DIGITS_IN_USE  = 1'b1
  } cfg_idx_t;

  // One scan step: buffer entry and display position it is shown on
  typedef struct packed {
    logic [2:0] idx;
    logic [2:0] pos;
  } scan_req_t;

  function automatic logic [7:0] digit_code(input logic [7:0] c);
    logic [3:0] d;
    logic [7:0] code;
    d = 4'(c - CHAR_ZERO);
    code = BLANK_CODE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      case (d)
        4'd0: code = 8'h3F;
        4'd1: code = 8'h06;
        4'd2: code = 8'h5B;
        4'd3: code = 8'h4F;
        4'd4: code = 8'h66;
        4'd5: code = 8'h6D;
        4'd6: code = 8'h7D;
        4'd7: code = 8'h07;
        4'd8: code = 8'h7F;
        4'd9: code = 8'h6F;
        default: code = BLANK_CODE;
      endcase
    end
    return code;
  endfunction

endpackage

[rtl/ssd_if.sv]
// ----------------------------------------------------------------------------
// ssd_in_if / ssd_out_if
// Valid/ready channels for input items and scan results.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] segments;
  logic [2:0] scan_position;

  modport source (output valid, output digit_select, output segments,
                  output scan_position, input ready);
  modport sink   (input valid, input digit_select, input segments,
                  input scan_position, output ready);
endinterface

[rtl/ssd_frame_store.sv]
// ----------------------------------------------------------------------------
// ssd_frame_store
// Double-banked segment memory. Bytes are encoded and written to the back
// bank; the fifth byte flips banks, committing the whole frame at once.
// ----------------------------------------------------------------------------
module ssd_frame_store
  import ssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_byte,
  input  logic       rd_en,
  input  logic [2:0] rd_idx,
  output logic [7:0] rd_code
);

  logic [7:0] mem [0:15];
  logic [2:0] count_r, count_nxt;
  logic       bank_r, bank_nxt;
  logic       shown_r, shown_nxt;
  logic [7:0] rd_q_r;
  logic       blank_r;
  logic [7:0] wr_code;

  always_comb begin
    if (count_r == 3'(DP_POS)) begin
      wr_code = (wr_byte == CHAR_DOT) ? DP_CODE : BLANK_CODE;
    end else begin
      wr_code = digit_code(wr_byte);
    end
  end

  always_comb begin
    count_nxt = count_r;
    bank_nxt  = bank_r;
    shown_nxt = shown_r;
    if (wr_en) begin
      if (count_r == 3'(FRAME_LEN - 1)) begin
        count_nxt = '0;
        bank_nxt  = ~bank_r;
        shown_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
      shown_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
      shown_r <= shown_nxt;
    end
  end

  // writes always land in the back bank, so reads never collide with them
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~bank_r, count_r}] <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r  <= mem[{bank_r, rd_idx}];
      blank_r <= !shown_r || (rd_idx >= 3'(FRAME_LEN));
    end
  end

  assign rd_code = blank_r ? BLANK_CODE : rd_q_r;

endmodule

[rtl/ssd_scanner.sv]
// ----------------------------------------------------------------------------
// ssd_scanner
// Holds the span registers and the scan index; clamps the span to the
// display and steps the index on each tick.
// ----------------------------------------------------------------------------
module ssd_scanner
  import ssd_pkg::*;
#(
  parameter int NUM_POSITIONS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_wdata,
  input  logic      tick,
  output scan_req_t req
);

  logic [2:0] first_r, first_nxt;
  logic [3:0] count_r, count_nxt;
  logic [2:0] scan_r, scan_nxt;
  logic [2:0] first_c;
  logic [3:0] limit;
  logic [3:0] span;
  logic [2:0] idx;
  logic [3:0] idx_inc;

  always_comb begin
    first_c = (first_r > 3'(NUM_POSITIONS - 1)) ? 3'(NUM_POSITIONS - 1) : first_r;
    limit   = 4'(NUM_POSITIONS) - {1'b0, first_c};
    span    = (count_r == 4'd0) ? 4'd1 : count_r;
    if (span > limit) span = limit;
    idx     = ({1'b0, scan_r} >= span) ? 3'd0 : scan_r;
    idx_inc = {1'b0, idx} + 4'd1;
    req.idx = idx;
    req.pos = first_c + idx;
  end

  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_POSITION: first_nxt = cfg_wdata[2:0];
        CFG_DIGITS_IN_USE:  count_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (tick) begin
      scan_nxt = (idx_inc >= span) ? 3'd0 : idx_inc[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      count_r <= 4'd8;
      scan_r  <= '0;
    end else begin
      first_r <= first_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule

[rtl/serial_seven_segment_display.sv]
// ----------------------------------------------------------------------------
// serial_seven_segment_display
// Pipeline: a scan tick's result is registered at the segment memory read,
// then at the output register. Bytes give no result.
// Throughput: one item per cycle while the output is not stalled; each item
// makes one memory access, a write for a byte or a read for a tick.
// Reset: synchronous, active low; clears counters, bank pointer, first position
// and pipeline valids, sets span to 8. Display reads blank until first frame.
// ----------------------------------------------------------------------------
module serial_seven_segment_display
  import ssd_pkg::*;
#(
  parameter int NUM_POSITIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  ssd_in_if.sink      in_ch,
  ssd_out_if.source   out_ch
);

  scan_req_t  req;
  logic       accept;
  logic       tick;
  logic       advance;
  logic       p_vld_r, p_vld_nxt;
  logic [2:0] p_pos_r;
  logic [2:0] p_idx_r;
  logic       o_vld_r, o_vld_nxt;
  logic [7:0] o_sel_r;
  logic [7:0] o_seg_r;
  logic [2:0] o_pos_r;
  logic [7:0] rd_code;

  assign advance     = !o_vld_r || out_ch.ready;
  assign in_ch.ready = !p_vld_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (op_t'(in_ch.operation) == OP_TICK);

  ssd_scanner #(.NUM_POSITIONS(NUM_POSITIONS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .req       (req)
  );

  ssd_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (op_t'(in_ch.operation) == OP_BYTE)),
    .wr_byte (in_ch.rx_byte),
    .rd_en   (tick),
    .rd_idx  (req.idx),
    .rd_code (rd_code)
  );

  always_comb begin
    p_vld_nxt = p_vld_r;
    o_vld_nxt = o_vld_r;
    if (advance) begin
      o_vld_nxt = p_vld_r;
      p_vld_nxt = 1'b0;
    end
    if (tick) p_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      p_pos_r <= req.pos;
      p_idx_r <= req.idx;
    end
    if (advance && p_vld_r) begin
      o_sel_r <= ~(8'd1 << p_pos_r);
      o_seg_r <= rd_code;
      o_pos_r <= p_idx_r;
    end
  end

  assign out_ch.valid         = o_vld_r;
  assign out_ch.digit_select  = o_sel_r;
  assign out_ch.segments      = o_seg_r;
  assign out_ch.scan_position = o_pos_r;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial seven-segment display driver. Serial
// bytes and scan ticks go in over valid/ready; every scan result is compared
// against a cycle-free model of the frame buffer and scan sequencer, under
// several span settings, random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import ssd_pkg::*;

  localparam int N_POS           = 8;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int IDLE_PCT        = 22;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [7:0] sel;
    logic [7:0] seg;
    logic [2:0] entry;
  } scan_result_t;

  class scan_scoreboard;
    scan_result_t expected_scans[$];
    int unsigned  failures;
    logic [2:0]   char_count;
    logic [7:0]   held[4];
    logic [7:0]   disp[N_POS];
    logic [2:0]   scan_idx;
    logic [2:0]   first_pos;
    logic [3:0]   span_len;
    logic [7:0]   seg_lut[10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                  8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    function new();
      failures   = 0;
      char_count = '0;
      scan_idx   = '0;
      first_pos  = 3'd0;
      span_len   = 4'd8;
      foreach (held[i]) held[i] = '0;
      foreach (disp[i]) disp[i] = BLANK_CODE;
    endfunction

    function logic [7:0] segment_code(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return seg_lut[c - CHAR_ZERO];
      return BLANK_CODE;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [3:0] data);
      if (idx == CFG_FIRST_POSITION) first_pos = data[2:0];
      else span_len = data;
    endfunction

    function void note_item(op_t op, logic [7:0] b);
      int count;
      int limit;
      int idx;
      scan_result_t r;
      if (op == OP_BYTE) begin
        if (char_count < FRAME_LEN - 1) begin
          held[char_count[1:0]] = b;
          char_count++;
        end else begin
          disp[0] = segment_code(held[0]);
          disp[1] = segment_code(held[1]);
          disp[2] = (held[2] == CHAR_DOT) ? DP_CODE : BLANK_CODE;
          disp[3] = segment_code(held[3]);
          disp[4] = segment_code(b);
          for (int i = FRAME_LEN; i < N_POS; i++) disp[i] = BLANK_CODE;
          char_count = '0;
        end
        return;
      end
      // span clamped to the display, zero treated as one
      limit = N_POS - int'(first_pos);
      count = (span_len == 0) ? 1 : int'(span_len);
      if (count > limit) count = limit;
      idx = int'(scan_idx);
      if (idx >= count) idx = 0;
      r.sel   = ~(8'd1 << ((int'(first_pos) + idx) & 7));
      r.seg   = disp[idx];
      r.entry = idx[2:0];
      expected_scans.push_back(r);
      idx++;
      if (idx >= count) idx = 0;
      scan_idx = idx[2:0];
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_scan(scan_result_t got);
      scan_result_t want;
      if (expected_scans.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected scan result sel=%h seg=%h pos=%0d",
                   got.sel, got.seg, got.entry);
        return;
      end
      want = expected_scans.pop_front();
      if (got.sel !== want.sel) report("digit_select", want.sel, got.sel);
      if (got.seg !== want.seg) report("segments", want.seg, got.seg);
      if (got.entry !== want.entry)
        report("scan_position", {5'd0, want.entry}, {5'd0, got.entry});
    endfunction

    function int pending();
      return expected_scans.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_wdata;
  logic       no_idle;
  int         byte_slot;
  int         cycles;

  ssd_in_if  in_ch();
  ssd_out_if out_ch();

  scan_scoreboard sb;

  serial_seven_segment_display #(.NUM_POSITIONS(N_POS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_scan(scan_result_t'({out_ch.digit_select, out_ch.segments,
                                    out_ch.scan_position}));

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(op_t op, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, b);
    if (op == OP_BYTE) byte_slot = (byte_slot + 1) % FRAME_LEN;
    @(negedge clk);
  endtask

  task automatic send_frame(logic [39:0] chars);
    for (int i = 0; i < FRAME_LEN; i++) send_item(OP_BYTE, chars[39 - 8*i -: 8]);
  endtask

  // valid stays low until all expected scan results are seen
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic program_span(logic [3:0] first_data, logic [3:0] span_data);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_POSITION;
    cfg_wdata <= first_data;
    @(posedge clk);
    sb.write_reg(CFG_FIRST_POSITION, first_data);
    @(negedge clk);
    cfg_index <= CFG_DIGITS_IN_USE;
    cfg_wdata <= span_data;
    @(posedge clk);
    sb.write_reg(CFG_DIGITS_IN_USE, span_data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    op_t        op;
    logic [7:0] b;
    op = $urandom_range(1) ? OP_TICK : OP_BYTE;
    b  = 8'($urandom_range(255));
    if (op == OP_BYTE && $urandom_range(99) < 85) begin
      // well-formed frame content, decimal point mostly in its slot
      if (byte_slot == DP_POS && $urandom_range(99) < 80) b = CHAR_DOT;
      else b = CHAR_ZERO + 8'($urandom_range(9));
    end
    send_item(op, b);
  endtask

  int phase_first[8] = '{7, 0, 3, 7, 0, 4, 2, 5};
  int phase_span[8]  = '{1, 0, 15, 15, 8, 3, 6, 2};

  initial begin
    logic [3:0] first_data;
    logic [3:0] span_data;
    sb              = new();
    cycles          = 0;
    byte_slot       = 0;
    no_idle         = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FIRST_POSITION;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_BYTE;
    in_ch.rx_byte   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: blank display, digits, non-dot point slot, out-of-range chars
    send_item(OP_TICK, 8'hFF);
    send_frame("01a34");
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_frame("56789");
    send_item(OP_TICK, 8'h00);
    send_frame({"/", ":", ".", 8'h00, 8'hFF});
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 8) begin
        first_data = 4'(phase_first[p]);
        span_data  = 4'(phase_span[p]);
      end else begin
        first_data = 4'($urandom_range(7));
        span_data  = 4'($urandom_range(15));
      end
      // top bit of the position write is don't-care
      first_data[3] = 1'($urandom_range(1));
      program_span(first_data, span_data);
      no_idle = (p == 5);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == ITEMS_PER_PHASE / 2) wait_results();
        send_random();
      end
    end
    no_idle = 1'b0;

    wait_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
